[hdl/pve_pkg.sv]
// Shared widths, constants and state encoding for the pose-to-velocity estimator.
package pve_pkg;

    localparam int RES_W      = 32;  // saturated result width
    localparam int NUM_W      = 56;  // rounded dividend width
    localparam int DEN_W      = 42;  // divisor width (interval shifted left by 11)
    localparam int LANES      = 6;   // divider lanes
    localparam int QLANES     = 4;   // lanes used for the quaternion normalization
    localparam int SQRT_STEPS = 31;  // result bits of the square root
    localparam int DIV_STEPS  = 32;  // quotient bits of one division
    localparam int CNT_W      = 5;

    localparam logic [19:0] US_PER_S = 20'd1000000;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SQSUM = 9'b000000010,
        ST_SQRT  = 9'b000000100,
        ST_NDIV  = 9'b000001000,
        ST_DIFF  = 9'b000010000,
        ST_CROSS = 9'b000100000,
        ST_SCALE = 9'b001000000,
        ST_ODIV  = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

endpackage

[hdl/pve_sqrt.sv]
// Iterative integer square root of a sum of squares scaled by 2^28, one bit per cycle.
module pve_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [32:0] sum_sq,
    output logic        done,
    output logic [30:0] root
);

    logic [61:0]                 n_reg, n_next;
    logic [32:0]                 rem_reg, rem_next;
    logic [30:0]                 root_reg, root_next;
    logic [pve_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [34:0]                 rem2;
    logic [34:0]                 trial;

    always_comb begin
        rem2      = {rem_reg, n_reg[61:60]};
        trial     = {2'b00, root_reg, 2'b01};
        n_next    = n_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            n_next    = {1'b0, sum_sq, 28'd0};
            rem_next  = '0;
            root_next = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            n_next = {n_reg[59:0], 2'b00};
            if (rem2 >= trial) begin
                rem_next  = 33'(rem2 - trial);
                root_next = {root_reg[29:0], 1'b1};
            end else begin
                rem_next  = rem2[32:0];
                root_next = {root_reg[29:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pve_pkg::CNT_W'(pve_pkg::SQRT_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[hdl/pve_div_lane.sv]
// One divider lane: restoring division of a rounded magnitude, signed and saturated to 32 bits.
module pve_div_lane (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic                               neg,
    input  logic [pve_pkg::NUM_W-1:0]          num,
    input  logic [pve_pkg::DEN_W-1:0]          den,
    output logic                               done,
    output logic signed [pve_pkg::RES_W-1:0]   result
);

    localparam int HI_W = pve_pkg::NUM_W - pve_pkg::DIV_STEPS;

    logic [pve_pkg::DIV_STEPS-1:0]  low_reg, low_next;
    logic [pve_pkg::DIV_STEPS-1:0]  quo_reg, quo_next;
    logic [pve_pkg::DEN_W:0]        rem_reg, rem_next;
    logic [pve_pkg::DEN_W-1:0]      den_reg, den_next;
    logic                           neg_reg, neg_next;
    logic                           ovf_reg, ovf_next;
    logic [pve_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [pve_pkg::DEN_W:0]        rem2;
    logic [pve_pkg::DEN_W:0]        den_ext;

    always_comb begin
        den_ext   = {1'b0, den_reg};
        rem2      = {rem_reg[pve_pkg::DEN_W-1:0], low_reg[pve_pkg::DIV_STEPS-1]};
        low_next  = low_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            low_next  = num[pve_pkg::DIV_STEPS-1:0];
            quo_next  = '0;
            rem_next  = (pve_pkg::DEN_W + 1)'(num[pve_pkg::NUM_W-1:pve_pkg::DIV_STEPS]);
            den_next  = den;
            neg_next  = neg;
            // The quotient cannot fit in 32 bits when the high part already reaches the divisor.
            ovf_next  = (pve_pkg::DEN_W + 1)'(num[pve_pkg::NUM_W-1:pve_pkg::DIV_STEPS])
                        >= (pve_pkg::DEN_W + 1)'(den);
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            low_next = {low_reg[pve_pkg::DIV_STEPS-2:0], 1'b0};
            if (rem2 >= den_ext) begin
                rem_next = rem2 - den_ext;
                quo_next = {quo_reg[pve_pkg::DIV_STEPS-2:0], 1'b1};
            end else begin
                rem_next = rem2;
                quo_next = {quo_reg[pve_pkg::DIV_STEPS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pve_pkg::CNT_W'(pve_pkg::DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_comb begin
        if (neg_reg) begin
            if (ovf_reg || quo_reg > {1'b1, {(pve_pkg::RES_W-1){1'b0}}}) begin
                result = {1'b1, {(pve_pkg::RES_W-1){1'b0}}};
            end else begin
                result = pve_pkg::RES_W'(0 - quo_reg);
            end
        end else begin
            if (ovf_reg || quo_reg[pve_pkg::DIV_STEPS-1]) begin
                result = {1'b0, {(pve_pkg::RES_W-1){1'b1}}};
            end else begin
                result = quo_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        low_reg <= low_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        ovf_reg <= ovf_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;

endmodule

[hdl/pose_to_velocity_estimator.sv]
// Top level: finite-difference linear velocity and body angular rate from timestamped poses.
//
//   Channel | Direction | Handshake          | Payload
//   s_      | in        | s_valid / s_ready  | pos_x/y/z, quat_w/x/y/z, time_us
//   m_      | out       | m_valid / m_ready  | vel_x/y/z, rate_x/y/z, estimate_valid,
//           |           |                    | bad_interval
//
// An item passes from acceptance to result through these steps: forming the sum of squares,
// the bit-serial square root (31 steps), two passes through the divider lanes (32 steps each),
// and the sequencing states. An item without a usable interval skips the second pass. The
// next item is accepted no earlier than the cycle after the result is registered, so items
// do not overlap.
// Reset (aresetn low, synchronous) clears the stored previous pose and the have-previous
// flag, so the first item afterwards yields zeros with both flags low.
// A finished result sits in the output register; the next item is accepted meanwhile, and
// the block only stalls at its final step if the earlier result has still not been taken.
module pose_to_velocity_estimator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [15:0] s_quat_w,
    input  logic signed [15:0] s_quat_x,
    input  logic signed [15:0] s_quat_y,
    input  logic signed [15:0] s_quat_z,
    input  logic        [31:0] s_time_us,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_vel_x,
    output logic signed [31:0] m_vel_y,
    output logic signed [31:0] m_vel_z,
    output logic signed [31:0] m_rate_x,
    output logic signed [31:0] m_rate_y,
    output logic signed [31:0] m_rate_z,
    output logic               m_estimate_valid,
    output logic               m_bad_interval
);

    pve_pkg::state_t state_reg, state_next;

    // Current item, captured at acceptance.
    logic signed [31:0] pos_reg [3];
    logic signed [15:0] raw_reg [4];
    logic        [31:0] time_reg;
    logic        [31:0] dt_reg;

    // Stored previous pose.
    logic signed [31:0] prev_pos_reg [3];
    logic signed [15:0] prev_q_reg [4];
    logic        [31:0] prev_time_reg;
    logic               have_prev_reg;

    // Intermediate results.
    logic signed [15:0] q_reg [4];
    logic signed [16:0] d_reg [4];
    logic signed [34:0] pv_reg [3];
    logic signed [32:0] pd_reg [3];
    logic        [30:0] r_reg;

    // Output register.
    logic               m_valid_reg;
    logic signed [31:0] vel_out_reg [3];
    logic signed [31:0] rate_out_reg [3];
    logic               est_valid_reg;
    logic               bad_reg;

    logic accept;
    logic item_valid;
    logic item_bad;
    logic out_free;

    // Square-root unit.
    logic [32:0] sum_sq;
    logic        sq_start;
    logic        sq_done;
    logic [30:0] sq_root;

    // Divider lanes.
    logic                               lane_start;
    logic                               lane_neg  [pve_pkg::LANES];
    logic [pve_pkg::NUM_W-1:0]          lane_num  [pve_pkg::LANES];
    logic [pve_pkg::DEN_W-1:0]          lane_den  [pve_pkg::LANES];
    logic                               lane_done [pve_pkg::LANES];
    logic signed [pve_pkg::RES_W-1:0]   lane_res  [pve_pkg::LANES];

    // Difference and cross-product logic.
    logic signed [15:0] qn   [4];
    logic signed [16:0] dd   [4];
    logic signed [16:0] aa   [4];
    logic signed [16:0] dsel [4];
    logic        [35:0] nd;
    logic        [35:0] na;
    logic signed [34:0] pv   [3];
    logic signed [34:0] qe   [4];
    logic signed [34:0] de   [4];

    // Scaling logic.
    logic [34:0] pv_mag [3];
    logic [32:0] pd_mag [3];

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == pve_pkg::ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // An interval is usable only when a previous pose exists and the wrapped difference is
    // strictly positive as a 32-bit signed value.
    assign item_valid = have_prev_reg && !dt_reg[31] && (dt_reg != '0);
    assign item_bad   = have_prev_reg && (dt_reg[31] || (dt_reg == '0));

    // Sum of squares of the raw quaternion; at most 2^32, so it fits in 33 bits.
    always_comb begin
        logic signed [33:0] acc;
        acc = '0;
        for (int i = 0; i < 4; i++) begin
            acc = acc + 34'(raw_reg[i] * raw_reg[i]);
        end
        sum_sq = acc[32:0];
    end

    assign sq_start = (state_reg == pve_pkg::ST_SQSUM);

    pve_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .sum_sq  (sum_sq),
        .done    (sq_done),
        .root    (sq_root)
    );

    // Lane inputs: the first pass normalizes the four quaternion components, the second
    // pass divides the three position differences and the three cross-product terms.
    assign lane_start = ((state_reg == pve_pkg::ST_SQRT) && sq_done)
                     || ((state_reg == pve_pkg::ST_SCALE) && item_valid);

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pv_mag[i] = pv_reg[i][34] ? 35'(-pv_reg[i]) : 35'(pv_reg[i]);
            pd_mag[i] = pd_reg[i][32] ? 33'(-pd_reg[i]) : 33'(pd_reg[i]);
        end
        for (int i = 0; i < pve_pkg::LANES; i++) begin
            lane_neg[i] = 1'b0;
            lane_num[i] = '0;
            lane_den[i] = '0;
        end
        if (state_reg == pve_pkg::ST_SQRT) begin
            for (int i = 0; i < pve_pkg::QLANES; i++) begin
                // The magnitude of the most negative component is 2^15, so it is taken
                // as an unsigned 16-bit value.
                lane_neg[i] = raw_reg[i][15];
                lane_num[i] = (pve_pkg::NUM_W'($unsigned(raw_reg[i][15] ? -raw_reg[i]
                                                                        : raw_reg[i])) << 28)
                            + pve_pkg::NUM_W'(sq_root >> 1);
                lane_den[i] = pve_pkg::DEN_W'(sq_root);
            end
        end else begin
            for (int i = 0; i < 3; i++) begin
                lane_neg[i]     = pd_reg[i][32];
                lane_num[i]     = pve_pkg::NUM_W'(pd_mag[i]) * pve_pkg::NUM_W'(pve_pkg::US_PER_S)
                                + pve_pkg::NUM_W'(dt_reg >> 1);
                lane_den[i]     = pve_pkg::DEN_W'(dt_reg);
                lane_neg[i + 3] = pv_reg[i][34];
                lane_num[i + 3] = pve_pkg::NUM_W'(pv_mag[i]) * pve_pkg::NUM_W'(pve_pkg::US_PER_S)
                                + (pve_pkg::NUM_W'(dt_reg) << 10);
                lane_den[i + 3] = pve_pkg::DEN_W'(dt_reg) << 11;
            end
        end
    end

    for (genvar g = 0; g < pve_pkg::LANES; g++) begin : g_lane
        pve_div_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (lane_start),
            .neg     (lane_neg[g]),
            .num     (lane_num[g]),
            .den     (lane_den[g]),
            .done    (lane_done[g]),
            .result  (lane_res[g])
        );
    end

    // Merge of the normalization lanes: clamp to Q2.14, and a zero root gives the zero
    // quaternion. Then pick the difference or sum with the smaller squared norm.
    always_comb begin
        nd = '0;
        na = '0;
        for (int i = 0; i < 4; i++) begin
            if (r_reg == '0) begin
                qn[i] = '0;
            end else if (lane_res[i] > 32'sd32767) begin
                qn[i] = 16'sh7fff;
            end else if (lane_res[i] < -32'sd32768) begin
                qn[i] = 16'sh8000;
            end else begin
                qn[i] = 16'(lane_res[i]);
            end
            dd[i] = 17'(qn[i]) - 17'(prev_q_reg[i]);
            aa[i] = 17'(qn[i]) + 17'(prev_q_reg[i]);
            nd    = nd + 36'(dd[i] * dd[i]);
            na    = na + 36'(aa[i] * aa[i]);
        end
        for (int i = 0; i < 4; i++) begin
            dsel[i] = (nd < na) ? dd[i] : aa[i];
        end
    end

    // Vector part of conj(q) * D with q = (w, x, y, z), in Q.28.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qe[i] = 35'(q_reg[i]);
            de[i] = 35'(d_reg[i]);
        end
        pv[0] = qe[0] * de[1] - de[0] * qe[1] - qe[2] * de[3] + qe[3] * de[2];
        pv[1] = qe[0] * de[2] - de[0] * qe[2] - qe[3] * de[1] + qe[1] * de[3];
        pv[2] = qe[0] * de[3] - de[0] * qe[3] - qe[1] * de[2] + qe[2] * de[1];
    end

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pve_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = pve_pkg::ST_SQSUM;
                end
            end
            pve_pkg::ST_SQSUM: begin
                state_next = pve_pkg::ST_SQRT;
            end
            pve_pkg::ST_SQRT: begin
                if (sq_done) begin
                    state_next = pve_pkg::ST_NDIV;
                end
            end
            pve_pkg::ST_NDIV: begin
                if (lane_done[0]) begin
                    state_next = pve_pkg::ST_DIFF;
                end
            end
            pve_pkg::ST_DIFF: begin
                state_next = pve_pkg::ST_CROSS;
            end
            pve_pkg::ST_CROSS: begin
                state_next = pve_pkg::ST_SCALE;
            end
            pve_pkg::ST_SCALE: begin
                state_next = item_valid ? pve_pkg::ST_ODIV : pve_pkg::ST_DONE;
            end
            pve_pkg::ST_ODIV: begin
                if (lane_done[0]) begin
                    state_next = pve_pkg::ST_DONE;
                end
            end
            pve_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = pve_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pve_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            pos_reg[0] <= s_pos_x;
            pos_reg[1] <= s_pos_y;
            pos_reg[2] <= s_pos_z;
            raw_reg[0] <= s_quat_w;
            raw_reg[1] <= s_quat_x;
            raw_reg[2] <= s_quat_y;
            raw_reg[3] <= s_quat_z;
            time_reg   <= s_time_us;
            dt_reg     <= s_time_us - prev_time_reg;
        end
        if (state_reg == pve_pkg::ST_SQRT && sq_done) begin
            r_reg <= sq_root;
        end
        if (state_reg == pve_pkg::ST_DIFF) begin
            for (int i = 0; i < 4; i++) begin
                q_reg[i] <= qn[i];
                d_reg[i] <= dsel[i];
            end
        end
        if (state_reg == pve_pkg::ST_CROSS) begin
            for (int i = 0; i < 3; i++) begin
                pv_reg[i] <= pv[i];
                pd_reg[i] <= 33'(pos_reg[i]) - 33'(prev_pos_reg[i]);
            end
        end
        if (state_reg == pve_pkg::ST_DONE && out_free) begin
            for (int i = 0; i < 3; i++) begin
                vel_out_reg[i]  <= item_valid ? lane_res[i] : '0;
                rate_out_reg[i] <= item_valid ? lane_res[i + 3] : '0;
            end
            est_valid_reg <= item_valid;
            bad_reg       <= item_bad;
        end
    end

    // Control state and the stored previous pose, which every item overwrites.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= pve_pkg::ST_IDLE;
            m_valid_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
            prev_time_reg <= '0;
            for (int i = 0; i < 3; i++) begin
                prev_pos_reg[i] <= '0;
            end
            for (int i = 0; i < 4; i++) begin
                prev_q_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == pve_pkg::ST_DONE && out_free) begin
                m_valid_reg   <= 1'b1;
                have_prev_reg <= 1'b1;
                prev_time_reg <= time_reg;
                for (int i = 0; i < 3; i++) begin
                    prev_pos_reg[i] <= pos_reg[i];
                end
                for (int i = 0; i < 4; i++) begin
                    prev_q_reg[i] <= q_reg[i];
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_vel_x          = vel_out_reg[0];
    assign m_vel_y          = vel_out_reg[1];
    assign m_vel_z          = vel_out_reg[2];
    assign m_rate_x         = rate_out_reg[0];
    assign m_rate_y         = rate_out_reg[1];
    assign m_rate_z         = rate_out_reg[2];
    assign m_estimate_valid = est_valid_reg;
    assign m_bad_interval   = bad_reg;

endmodule

[sim/testbench.sv]
// Self-checking testbench for the pose-to-velocity estimator.

typedef struct {
    logic signed [31:0] pos [3];
    logic signed [15:0] quat [4];
    logic        [31:0] time_us;
} pose_t;

typedef struct {
    logic signed [31:0] vel [3];
    logic signed [31:0] rate [3];
    logic               est_valid;
    logic               bad_int;
} motion_t;

class motion_scoreboard;
    longint      last_pos [3];
    longint      last_quat [4];
    logic [31:0] last_time;
    bit          seen_pose;
    motion_t     expected_motion [$];
    int          errors;

    function new();
        for (int i = 0; i < 3; i++) last_pos[i] = 0;
        for (int i = 0; i < 4; i++) last_quat[i] = 0;
        last_time = 0;
        seen_pose = 0;
        errors = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Rounded division, ties away from zero, magnitude clamped at 2^40.
    function longint round_div(longint num, longint unsigned den);
        longint unsigned mag, q;
        mag = (num < 0) ? longint'(0) - num : num;
        q = (mag + den / 2) / den;
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function void note_pose(pose_t p);
        longint          raw [4], q [4], d [4], a [4], pv [3], vel [3], rate [3];
        longint unsigned sq, r;
        longint          nd, na, dt;
        logic [31:0]     dt32;
        motion_t         m;
        sq = 0; nd = 0; na = 0;
        for (int i = 0; i < 3; i++) begin
            vel[i] = 0;
            rate[i] = 0;
        end
        dt32 = p.time_us - last_time;
        dt = longint'($signed(dt32));
        for (int i = 0; i < 4; i++) begin
            raw[i] = p.quat[i];
            sq += raw[i] * raw[i];
        end
        r = int_sqrt(sq << 28);
        for (int i = 0; i < 4; i++)
            q[i] = (r == 0) ? 0 : clamp(round_div(raw[i] * 268435456, r), -32768, 32767);
        for (int i = 0; i < 4; i++) begin
            d[i] = q[i] - last_quat[i];
            a[i] = q[i] + last_quat[i];
            nd += d[i] * d[i];
            na += a[i] * a[i];
        end
        if (!(nd < na))
            for (int i = 0; i < 4; i++) d[i] = a[i];
        m.bad_int = seen_pose && dt <= 0;
        m.est_valid = seen_pose && dt > 0;
        if (m.est_valid) begin
            pv[0] = q[0]*d[1] - d[0]*q[1] - (q[2]*d[3] - q[3]*d[2]);
            pv[1] = q[0]*d[2] - d[0]*q[2] - (q[3]*d[1] - q[1]*d[3]);
            pv[2] = q[0]*d[3] - d[0]*q[3] - (q[1]*d[2] - q[2]*d[1]);
            for (int i = 0; i < 3; i++) begin
                vel[i] = round_div((longint'(p.pos[i]) - last_pos[i]) * 1000000, dt);
                rate[i] = round_div(pv[i] * 1000000, longint'(dt) << 11);
            end
        end
        for (int i = 0; i < 3; i++) begin
            m.vel[i] = 32'(clamp(vel[i], -64'sh80000000, 64'sh7fffffff));
            m.rate[i] = 32'(clamp(rate[i], -64'sh80000000, 64'sh7fffffff));
            last_pos[i] = p.pos[i];
        end
        for (int i = 0; i < 4; i++) last_quat[i] = q[i];
        last_time = p.time_us;
        seen_pose = 1;
        expected_motion.push_back(m);
    endfunction

    task report(string msg);
        $display("MISMATCH: %s", msg);
        errors++;
    endtask

    task check_motion(motion_t got);
        motion_t e;
        if (expected_motion.size() == 0) begin
            report("result with no pending expectation");
            return;
        end
        e = expected_motion.pop_front();
        for (int i = 0; i < 3; i++) begin
            if (got.vel[i] !== e.vel[i])
                report($sformatf("vel[%0d] got %0d exp %0d", i, got.vel[i], e.vel[i]));
            if (got.rate[i] !== e.rate[i])
                report($sformatf("rate[%0d] got %0d exp %0d", i, got.rate[i], e.rate[i]));
        end
        if (got.est_valid !== e.est_valid)
            report($sformatf("estimate_valid got %b exp %b", got.est_valid, e.est_valid));
        if (got.bad_int !== e.bad_int)
            report($sformatf("bad_interval got %b exp %b", got.bad_int, e.bad_int));
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM  = 1430;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 800;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic signed [31:0] s_pos_x = 0, s_pos_y = 0, s_pos_z = 0;
    logic signed [15:0] s_quat_w = 0, s_quat_x = 0, s_quat_y = 0, s_quat_z = 0;
    logic        [31:0] s_time_us = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic signed [31:0] m_vel_x, m_vel_y, m_vel_z, m_rate_x, m_rate_y, m_rate_z;
    logic               m_estimate_valid, m_bad_interval;

    motion_scoreboard sb = new();
    int               sent_count = 0;
    int               got_count = 0;
    bit               sender_done = 0;
    logic [31:0]      clock_us = 0;

    pose_to_velocity_estimator u_top (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Neither side idles while the item count sits in this window.
    function automatic bit quiet_window(int n);
        return n >= 600 && n < 800;
    endfunction

    // Present one item, with an optional random gap in front, and hold it until taken.
    task automatic send_pose(pose_t p);
        int gap;
        gap = 0;
        if (!quiet_window(sent_count) && $urandom_range(99) < 26)
            gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_pos_x   <= p.pos[0];
        s_pos_y   <= p.pos[1];
        s_pos_z   <= p.pos[2];
        s_quat_w  <= p.quat[0];
        s_quat_x  <= p.quat[1];
        s_quat_y  <= p.quat[2];
        s_quat_z  <= p.quat[3];
        s_time_us <= p.time_us;
        do @(posedge aclk); while (!s_ready);
        sb.note_pose(p);
        sent_count++;
    endtask

    task automatic send_fields(int px, int py, int pz, int qw, int qx, int qy, int qz,
                               logic [31:0] t);
        pose_t p;
        p.pos[0] = px; p.pos[1] = py; p.pos[2] = pz;
        p.quat[0] = 16'(qw); p.quat[1] = 16'(qx); p.quat[2] = 16'(qy); p.quat[3] = 16'(qz);
        p.time_us = t;
        send_pose(p);
    endtask

    // Builds a random pose. Most items are a smooth trajectory with a near-unit quaternion
    // and a short positive interval; the rest stress wide values and bad intervals.
    task automatic send_random_pose();
        pose_t p;
        int    kind;
        kind = $urandom_range(99);
        if (kind < 70)
            clock_us = clock_us + $urandom_range(1, 20000);
        else if (kind < 78)
            clock_us = clock_us;
        else if (kind < 86)
            clock_us = clock_us - $urandom_range(0, 100000);
        else
            clock_us = $urandom;
        p.time_us = clock_us;
        for (int i = 0; i < 3; i++)
            p.pos[i] = (kind < 60) ? int'(sb.last_pos[i]) + $signed($urandom_range(0, 131072))
                                     - 65536
                                   : $urandom;
        for (int i = 0; i < 4; i++) begin
            if (kind < 60)
                p.quat[i] = 16'(int'(sb.last_quat[i]) + $signed($urandom_range(0, 2000))
                                - 1000);
            else if (kind < 65)
                p.quat[i] = 0;
            else
                p.quat[i] = 16'($urandom);
        end
        // Occasionally present the sign-flipped quaternion to exercise the sum branch.
        if (kind < 60 && $urandom_range(9) == 0)
            for (int i = 0; i < 4; i++) p.quat[i] = -p.quat[i];
        send_pose(p);
    endtask

    // Receiver: checks results, stalls at random, and once holds off for a long stretch.
    initial begin
        motion_t got;
        int      hold;
        bit      held;
        hold = 0;
        held = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                got.vel[0] = m_vel_x;  got.vel[1] = m_vel_y;  got.vel[2] = m_vel_z;
                got.rate[0] = m_rate_x; got.rate[1] = m_rate_y; got.rate[2] = m_rate_z;
                got.est_valid = m_estimate_valid;
                got.bad_int = m_bad_interval;
                sb.check_motion(got);
                got_count++;
            end
            if (!held && got_count == 200) begin
                held = 1;
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (quiet_window(got_count)) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 26);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    initial begin
        int idle;
        idle = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
            if (idle >= STALL_LIMIT) begin
                $display("testbench: done, errors");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: first sample, extremes, zero and degenerate quaternions,
        // zero and negative intervals, and a timestamp wrap.
        send_fields(100, -100, 0, 16384, 0, 0, 0, 32'd1000);
        send_fields(32'h7fffffff, 32'h80000000, 0, 16384, 0, 0, 0, 32'd1001);
        send_fields(32'h80000000, 32'h7fffffff, 32'hffffffff, 16384, 0, 0, 0, 32'd1002);
        send_fields(0, 0, 0, 0, 0, 0, 0, 32'd2000);
        send_fields(65536, 65536, 65536, 16384, 0, 0, 0, 32'd2000);
        send_fields(0, 0, 0, 0, 16384, 0, 0, 32'd1500);
        send_fields(0, 0, 0, -16384, 0, 0, 0, 32'd1600);
        send_fields(0, 0, 0, 32767, 32767, 32767, 32767, 32'd1601);
        send_fields(0, 0, 0, -32768, -32768, -32768, -32768, 32'd1602);
        send_fields(0, 0, 0, -32768, 0, 0, 0, 32'd1603);
        send_fields(0, 0, 0, 0, 0, 0, 32767, 32'd1604);
        send_fields(0, 0, 0, 1, 0, 0, 0, 32'd1605);
        send_fields(0, 0, 0, 11585, 11585, 0, 0, 32'hffffff00);
        send_fields(1000, 2000, 3000, 11585, 0, 11585, 0, 32'h00000100);
        send_fields(-1000, -2000, -3000, -11585, 0, -11585, 0, 32'h80000100);
        send_fields(0, 0, 0, 16384, 0, 0, 0, 32'h00000100);
        send_fields(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 16384, 0, 0, 0, 32'h80000000);
        send_fields(0, 0, 0, 0, 0, 0, 0, 32'h80000001);
        send_fields(5, 5, 5, 16384, 0, 0, 0, 32'h80000002);
        clock_us = 32'h80000002;

        repeat (NUM_RANDOM) send_random_pose();
        s_valid <= 1'b0;
        sender_done = 1;

        wait (sb.expected_motion.size() == 0);
        repeat (300) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_motion.size() == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
